FILE: rtl/sdbl_pkg.sv
// ----------------------------------------------------------------------------
// sdbl_pkg
// Shared types, grid constants and cell search for the star density lookup.
// ----------------------------------------------------------------------------
package sdbl_pkg;

    localparam int MAG_BINS  = 32;
    localparam int LON_NODES = 6;
    localparam int LAT_NODES = 9;

    localparam int BIN_W      = $clog2(MAG_BINS);
    localparam int LAT_CELL_W = $clog2(LAT_NODES);
    localparam int LON_CELL_W = $clog2(LON_NODES);
    localparam int BIN_STRIDE = LAT_NODES * LON_NODES;
    localparam int TBL_DEPTH  = MAG_BINS * BIN_STRIDE;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);

    localparam int CNT_W   = 24;
    localparam int SUM_W   = 29;
    localparam int OFF_W   = 14;
    localparam int FRAC_W  = 17;
    localparam int LERP_W  = 30;

    localparam int LAT_GRID [LAT_NODES] =
        '{-9000, -6000, -3000, -1000, 0, 1000, 3000, 6000, 9000};
    localparam int LON_GRID [LON_NODES] = '{0, 1000, 9000, 18000, 27000, 36000};

    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_BREAK = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_NONE  = 2'd3
    } sdbl_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOC_LAT,
        ST_DIV_LAT,
        ST_LOC_LON,
        ST_DIV_LON,
        ST_SUM,
        ST_SUM_TAIL,
        ST_LERP,
        ST_FINISH
    } sdbl_state_t;

    typedef struct packed {
        logic             start;
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] width;
    } sdbl_div_req_t;

    typedef struct packed {
        logic                     start;
        logic signed [LERP_W-1:0] a;
        logic signed [LERP_W-1:0] b;
        logic [FRAC_W-1:0]        frac;
    } sdbl_lerp_req_t;

    function automatic logic [LAT_CELL_W-1:0] lat_cell(input logic signed [15:0] pos);
        logic [LAT_CELL_W-1:0] c;
        c = LAT_CELL_W'(LAT_NODES - 2);
        for (int i = 0; i < LAT_NODES - 1; i++) begin
            if (LAT_GRID[i] <= int'(pos) && int'(pos) < LAT_GRID[i+1])
            begin
                c = LAT_CELL_W'(i);
            end
        end
        return c;
    endfunction

    function automatic logic [LON_CELL_W-1:0] lon_cell(input logic [15:0] pos);
        logic [LON_CELL_W-1:0] c;
        c = LON_CELL_W'(LON_NODES - 2);
        for (int i = 0; i < LON_NODES - 1; i++) begin
            if (LON_GRID[i] <= int'(pos) && int'(pos) < LON_GRID[i+1])
            begin
                c = LON_CELL_W'(i);
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/sdbl_ram.sv
// ----------------------------------------------------------------------------
// sdbl_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sdbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/sdbl_frac_div.sv
// ----------------------------------------------------------------------------
// sdbl_frac_div
// Bit-serial divider: Q1.16 fraction offset*65536/width, offset <= width.
// ----------------------------------------------------------------------------
module sdbl_frac_div
    import sdbl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  sdbl_div_req_t       req,
    output logic                done,
    output logic [FRAC_W-1:0]   quot
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [OFF_W:0]      rem_reg, rem_next;
    logic [OFF_W-1:0]    wid_reg, wid_next;
    logic [FRAC_W-1:0]   q_reg, q_next;
    logic [OFF_W+1:0]    cand;
    logic                ge;

    // first step tests the integer bit without a shift
    always_comb
    begin
        cand = (cnt_reg == 5'd0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge   = cand >= {2'b00, wid_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        wid_next  = wid_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = {1'b0, req.offset};
            wid_next  = req.width;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (OFF_W+1)'(cand - {2'b00, wid_reg}) : (OFF_W+1)'(cand);
            q_next   = {q_reg[FRAC_W-2:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        wid_reg <= wid_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: rtl/sdbl_lerp.sv
// ----------------------------------------------------------------------------
// sdbl_lerp
// Shared interpolation unit: a + trunc(frac*(b-a)/65536).
// ----------------------------------------------------------------------------
module sdbl_lerp
    import sdbl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sdbl_lerp_req_t           req,
    output logic                     done,
    output logic signed [LERP_W-1:0] res
);

    localparam int PROD_W = LERP_W + FRAC_W + 2;

    logic                     mul_vld_reg, done_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [LERP_W-1:0] a_reg, res_reg;
    logic signed [LERP_W:0]   diff;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [PROD_W-1:0] quo;
    logic signed [LERP_W:0]   sum;

    assign diff = (LERP_W+1)'(req.b) - (LERP_W+1)'(req.a);

    // round toward zero on negative products
    always_comb
    begin
        prod_adj = prod_reg[PROD_W-1] ? prod_reg + PROD_W'(65535) : prod_reg;
        quo      = prod_adj >>> 16;
        sum      = (LERP_W+1)'(a_reg) + (LERP_W+1)'(quo[LERP_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= req.start;
            done_reg    <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= PROD_W'($signed({1'b0, req.frac}) * diff);
            a_reg    <= req.a;
        end
        if (mul_vld_reg)
        begin
            res_reg <= sum[LERP_W-1:0];
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: rtl/star_density_bilinear_lookup_core.sv
// ----------------------------------------------------------------------------
// star_density_bilinear_lookup_core
// Magnitude-binned star count lookup with bilinear interpolation on a
// galactic longitude/latitude grid.
// ----------------------------------------------------------------------------
//  channel | handshake            | beat
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | command, position, magnitudes, load addr
//  out     | out_valid / out_stall| estimated_stars (one beat per query)
//
//  A query runs a breakpoint scan over all bins, two divider runs (setup,
//  17 quotient steps, done), (hi-lo+1)*4 count reads, three interpolations
//  and a finish state; its length is set by the single count RAM port and
//  the shared divider.
//  in_stall is high whenever a query is in flight. A finished result waits
//  in the output register; the next beat is accepted meanwhile.
//  Reset clears control only; tables are undefined until loaded.
// ----------------------------------------------------------------------------
module star_density_bilinear_lookup_core
    import sdbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [15:0]          lon_position,
    input  logic signed [14:0]   lat_position,
    input  logic signed [12:0]   min_magnitude,
    input  logic signed [12:0]   max_magnitude,
    input  logic [4:0]           bin_index,
    input  logic [3:0]           lat_node,
    input  logic [2:0]           lon_node,
    input  logic [23:0]          load_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SUM_W-1:0]     estimated_stars
);

    sdbl_state_t state_reg, state_next;

    logic in_acc;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // latched query
    logic [15:0]        lon_reg;
    logic signed [14:0] lat_reg;
    logic signed [12:0] mmin_reg, mmax_reg;

    // breakpoint scan
    logic [BIN_W:0]     scan_reg;
    logic               lo_found_reg, hi_found_reg;
    logic [BIN_W-1:0]   lo_reg, hi_reg;
    logic [BIN_W-1:0]   scan_bin;
    logic signed [15:0] brk_rdata;
    logic               brk_we;
    logic [BIN_W-1:0]   brk_addr;
    logic               lo_hit, hi_hit;
    logic [BIN_W-1:0]   lo_eff, hi_eff;

    assign scan_bin = BIN_W'(scan_reg - 1'b1);
    assign lo_hit   = brk_rdata >= 16'(mmin_reg);
    assign hi_hit   = (brk_rdata >= 16'(mmax_reg)) || (scan_bin == BIN_W'(MAG_BINS - 1));
    // bin bounds including the last bin, which is still being latched
    assign lo_eff   = lo_found_reg ? lo_reg : scan_bin;
    assign hi_eff   = hi_found_reg ? hi_reg : scan_bin;

    // locate
    logic signed [15:0]    lat_cl;
    logic [15:0]           lon_cl;
    logic [LAT_CELL_W-1:0] lat_c, lat_c_reg;
    logic [LON_CELL_W-1:0] lon_c;
    logic [FRAC_W-1:0]     flat_reg, flon_reg;

    always_comb
    begin
        lat_cl = 16'(lat_reg);
        if (lat_cl < 16'(LAT_GRID[0]))
        begin
            lat_cl = 16'(LAT_GRID[0]);
        end
        if (lat_cl > 16'(LAT_GRID[LAT_NODES-1]))
        begin
            lat_cl = 16'(LAT_GRID[LAT_NODES-1]);
        end
        lon_cl = (int'(lon_reg) > LON_GRID[LON_NODES-1]) ?
                 16'(LON_GRID[LON_NODES-1]) : lon_reg;
        lat_c = lat_cell(lat_cl);
        lon_c = lon_cell(lon_cl);
    end

    // shared divider
    sdbl_div_req_t     div_req;
    logic              div_done;
    logic [FRAC_W-1:0] div_q;

    always_comb
    begin
        div_req = '0;
        if (state_reg == ST_LOC_LAT)
        begin
            div_req.start  = 1'b1;
            div_req.offset = OFF_W'(int'(lat_cl) - LAT_GRID[lat_c]);
            div_req.width  = OFF_W'(LAT_GRID[lat_c+1] - LAT_GRID[lat_c]);
        end
        else if (state_reg == ST_LOC_LON)
        begin
            div_req.start  = 1'b1;
            div_req.offset = OFF_W'(int'(lon_cl) - LON_GRID[lon_c]);
            div_req.width  = OFF_W'(LON_GRID[lon_c+1] - LON_GRID[lon_c]);
        end
    end

    sdbl_frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    // count summation
    logic [TBL_AW-1:0] base_reg, addr_reg, wr_addr, cnt_addr;
    logic [1:0]        corner_reg, acc_corner_reg;
    logic [BIN_W-1:0]  bin_reg;
    logic              acc_vld_reg;
    logic [SUM_W-1:0]  csum_reg [4];
    logic [CNT_W-1:0]  cnt_rdata;
    logic              cnt_we;
    logic [1:0]        corner_nx;

    assign corner_nx = corner_reg + 2'd1;
    assign wr_addr   = TBL_AW'(int'(bin_index) * BIN_STRIDE
                       + int'(lat_node) * LON_NODES + int'(lon_node));
    assign cnt_we    = in_acc && (command == CMD_COUNT)
                       && (int'(lat_node) < LAT_NODES) && (int'(lon_node) < LON_NODES);
    assign cnt_addr  = (state_reg == ST_IDLE) ? wr_addr : addr_reg;
    assign brk_we    = in_acc && (command == CMD_BREAK);
    assign brk_addr  = (state_reg == ST_IDLE) ? bin_index : scan_reg[BIN_W-1:0];

    sdbl_ram #(.WIDTH(16), .DEPTH(MAG_BINS)) u_brk_ram (
        .clk   (clk),
        .we    (brk_we),
        .addr  (brk_addr),
        .wdata (load_value[15:0]),
        .rdata (brk_rdata)
    );

    sdbl_ram #(.WIDTH(CNT_W), .DEPTH(TBL_DEPTH)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .addr  (cnt_addr),
        .wdata (load_value),
        .rdata (cnt_rdata)
    );

    // interpolation
    logic [1:0]                lerp_idx_reg;
    logic                      lerp_go_reg;
    logic signed [LERP_W-1:0]  low_reg, high_reg;
    sdbl_lerp_req_t            lerp_req;
    logic                      lerp_done;
    logic signed [LERP_W-1:0]  lerp_res;
    logic [SUM_W-1:0]          result_reg;

    always_comb
    begin
        lerp_req       = '0;
        lerp_req.start = (state_reg == ST_LERP) && lerp_go_reg;
        case (lerp_idx_reg)
            2'd0:
            begin
                lerp_req.a    = LERP_W'(csum_reg[0]);
                lerp_req.b    = LERP_W'(csum_reg[1]);
                lerp_req.frac = flon_reg;
            end
            2'd1:
            begin
                lerp_req.a    = LERP_W'(csum_reg[2]);
                lerp_req.b    = LERP_W'(csum_reg[3]);
                lerp_req.frac = flon_reg;
            end
            default:
            begin
                lerp_req.a    = low_reg;
                lerp_req.b    = high_reg;
                lerp_req.frac = flat_reg;
            end
        endcase
    end

    sdbl_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .done  (lerp_done),
        .res   (lerp_res)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && command == CMD_QUERY)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == (BIN_W+1)'(MAG_BINS))
                begin
                    if (!(lo_found_reg || lo_hit))
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (hi_eff < lo_eff)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LOC_LAT;
                    end
                end
            end
            ST_LOC_LAT: state_next = ST_DIV_LAT;
            ST_DIV_LAT: state_next = div_done ? ST_LOC_LON : ST_DIV_LAT;
            ST_LOC_LON: state_next = ST_DIV_LON;
            ST_DIV_LON: state_next = div_done ? ST_SUM : ST_DIV_LON;
            ST_SUM:
            begin
                if (bin_reg == hi_reg && corner_reg == 2'd3)
                begin
                    state_next = ST_SUM_TAIL;
                end
            end
            ST_SUM_TAIL: state_next = ST_LERP;
            ST_LERP:
            begin
                if (lerp_done && lerp_idx_reg == 2'd2)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg       <= '0;
            lo_found_reg   <= 1'b0;
            hi_found_reg   <= 1'b0;
            acc_vld_reg    <= 1'b0;
            lerp_go_reg    <= 1'b0;
            lerp_idx_reg   <= '0;
            corner_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            acc_vld_reg <= (state_reg == ST_SUM);
            lerp_go_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    scan_reg     <= '0;
                    lo_found_reg <= 1'b0;
                    hi_found_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg != '0)
                    begin
                        if (lo_hit)
                        begin
                            lo_found_reg <= 1'b1;
                        end
                        if (hi_hit)
                        begin
                            hi_found_reg <= 1'b1;
                        end
                    end
                end
                ST_DIV_LON:
                begin
                    corner_reg <= '0;
                end
                ST_SUM:
                begin
                    if (bin_reg == hi_reg)
                    begin
                        corner_reg <= corner_nx;
                    end
                end
                ST_SUM_TAIL:
                begin
                    lerp_go_reg  <= 1'b1;
                    lerp_idx_reg <= '0;
                end
                ST_LERP:
                begin
                    if (lerp_done && lerp_idx_reg != 2'd2)
                    begin
                        lerp_idx_reg <= lerp_idx_reg + 2'd1;
                        lerp_go_reg  <= 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            lon_reg    <= lon_position;
            lat_reg    <= lat_position;
            mmin_reg   <= min_magnitude;
            mmax_reg   <= max_magnitude;
            result_reg <= '0;
        end
        if (state_reg == ST_SCAN && scan_reg != '0)
        begin
            if (!lo_found_reg && lo_hit)
            begin
                lo_reg <= scan_bin;
            end
            if (!hi_found_reg && hi_hit)
            begin
                hi_reg <= scan_bin;
            end
        end
        if (state_reg == ST_LOC_LAT)
        begin
            lat_c_reg <= lat_c;
        end
        if (state_reg == ST_DIV_LAT && div_done)
        begin
            flat_reg <= div_q;
        end
        if (state_reg == ST_LOC_LON)
        begin
            base_reg <= TBL_AW'(int'(lo_reg) * BIN_STRIDE
                        + int'(lat_c_reg) * LON_NODES + int'(lon_c));
        end
        if (state_reg == ST_DIV_LON && div_done)
        begin
            flon_reg <= div_q;
            addr_reg <= base_reg;
            bin_reg  <= lo_reg;
            for (int k = 0; k < 4; k++)
            begin
                csum_reg[k] <= '0;
            end
        end
        if (state_reg == ST_SUM)
        begin
            acc_corner_reg <= corner_reg;
            if (bin_reg == hi_reg)
            begin
                bin_reg  <= lo_reg;
                // corner offsets: +1 lon node, +LON_NODES lat node
                addr_reg <= TBL_AW'(int'(base_reg) + int'(corner_nx[1]) * LON_NODES
                            + int'(corner_nx[0]));
            end
            else
            begin
                bin_reg  <= bin_reg + 1'b1;
                addr_reg <= TBL_AW'(int'(addr_reg) + BIN_STRIDE);
            end
        end
        if (acc_vld_reg)
        begin
            csum_reg[acc_corner_reg] <= SUM_W'(csum_reg[acc_corner_reg] + SUM_W'(cnt_rdata));
        end
        if (state_reg == ST_LERP && lerp_done)
        begin
            case (lerp_idx_reg)
                2'd0:    low_reg  <= lerp_res;
                2'd1:    high_reg <= lerp_res;
                default: result_reg <= lerp_res[LERP_W-1] ? '0 : lerp_res[SUM_W-1:0];
            endcase
        end
        if (state_reg == ST_FINISH && (!out_valid_reg || !out_stall))
        begin
            estimated_stars <= result_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> (flat_reg <= FRAC_W'(65536)))
        else $error("fraction beyond one");

    a_table_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_we || brk_we) |-> (state_reg == ST_IDLE))
        else $error("table write during query");

endmodule

FILE: tb/sv/star_density_bilinear_lookup_checker.sv
// ----------------------------------------------------------------------------
// star_density_bilinear_lookup_checker
// Watches both channels of the star density lookup, keeps its own copy of
// the breakpoint and count tables, predicts each query answer and compares.
// ----------------------------------------------------------------------------
module star_density_bilinear_lookup_checker
    import sdbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         command,
    input  logic [15:0]        lon_position,
    input  logic signed [14:0] lat_position,
    input  logic signed [12:0] min_magnitude,
    input  logic signed [12:0] max_magnitude,
    input  logic [4:0]         bin_index,
    input  logic [3:0]         lat_node,
    input  logic [2:0]         lon_node,
    input  logic [23:0]        load_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [28:0]        estimated_stars,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_AXIS [9] = '{-9000, -6000, -3000, -1000, 0, 1000, 3000, 6000, 9000};
    localparam int LON_AXIS [6] = '{0, 1000, 9000, 18000, 27000, 36000};

    int          breakpoints [32];
    int          star_counts [1728];
    logic [28:0] stars_due [$];

    function automatic void grid_cell(input bit on_lat, input int pos,
                                      output int cell_idx, output longint frac);
        int nodes;
        int g [9];
        nodes = on_lat ? 9 : 6;
        for (int i = 0; i < 9; i++)
        begin
            g[i] = on_lat ? LAT_AXIS[i] : (i < 6 ? LON_AXIS[i] : 0);
        end
        if (pos < g[0]) pos = g[0];
        if (pos > g[nodes-1]) pos = g[nodes-1];
        cell_idx = nodes - 2;
        for (int i = nodes - 2; i >= 0; i--)
        begin
            if (g[i] <= pos && pos < g[i+1]) cell_idx = i;
        end
        frac = (longint'(pos - g[cell_idx]) * 65536)
               / longint'(g[cell_idx+1] - g[cell_idx]);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return a + (f * (b - a)) / 65536;
    endfunction

    function automatic logic [28:0] interpolate_stars(input int lon, input int lat,
                                                      input int mn, input int mx);
        int     lo_bin;
        int     hi_bin;
        int     lat_c;
        int     lon_c;
        longint f_lat;
        longint f_lon;
        longint corner [2][2];
        longint low;
        longint high;
        longint r;
        lo_bin = -1;
        hi_bin = -1;
        for (int b = 0; b < 32; b++)
        begin
            if (lo_bin < 0 && breakpoints[b] >= mn) lo_bin = b;
            if (hi_bin < 0 && (breakpoints[b] >= mx || b == 31)) hi_bin = b;
        end
        if (lo_bin < 0 || hi_bin < lo_bin) return '0;
        grid_cell(1'b1, lat, lat_c, f_lat);
        grid_cell(1'b0, lon, lon_c, f_lon);
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                corner[i][j] = 0;
                for (int b = lo_bin; b <= hi_bin; b++)
                begin
                    corner[i][j] += star_counts[(b * 9 + lat_c + i) * 6 + lon_c + j];
                end
            end
        end
        low  = blend(corner[0][0], corner[0][1], f_lon);
        high = blend(corner[1][0], corner[1][1], f_lon);
        r    = blend(low, high, f_lat);
        if (r < 0) r = 0;
        return r[28:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                case (sdbl_cmd_t'(command))
                    CMD_QUERY:
                        stars_due.push_back(interpolate_stars(int'(lon_position),
                            int'(lat_position), int'(min_magnitude), int'(max_magnitude)));
                    CMD_BREAK:
                        breakpoints[bin_index] = int'(signed'(load_value[15:0]));
                    CMD_COUNT:
                        if (lat_node < 9 && lon_node < 6)
                            star_counts[(bin_index * 9 + lat_node) * 6 + lon_node] =
                                int'(load_value);
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (stars_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat: estimated_stars=%0d",
                                 estimated_stars);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (stars_due[0] !== estimated_stars)
                    begin
                        if (fail_count < 10)
                            $display("estimated_stars: expected %0d, got %0d",
                                     stars_due[0], estimated_stars);
                        fail_count <= fail_count + 1;
                    end
                    void'(stars_due.pop_front());
                end
            end
            pending <= stars_due.size();
        end
    end
endmodule

FILE: tb/sv/star_density_bilinear_lookup_core_test.sv
// ----------------------------------------------------------------------------
// star_density_bilinear_lookup_core_test
// Loads every breakpoint and count, then runs directed and random queries and
// table rewrites against the lookup core with random idling on both sides.
// ----------------------------------------------------------------------------
module star_density_bilinear_lookup_core_test;
    import sdbl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic [15:0]        lon_position;
    logic signed [14:0] lat_position;
    logic signed [12:0] min_magnitude;
    logic signed [12:0] max_magnitude;
    logic [4:0]         bin_index;
    logic [3:0]         lat_node;
    logic [2:0]         lon_node;
    logic [23:0]        load_value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [28:0]        estimated_stars;
    int                 fail_count;
    int                 pending;

    bit                 calm;            // no idling on either side while set
    int                 out_hold = 0;    // cycles left to stall the result channel
    int                 idle_cycles = 0; // watchdog: cycles with no beat on either side

    star_density_bilinear_lookup_core DUT (.*);

    star_density_bilinear_lookup_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result side: stall for a random count of cycles before each beat.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            out_hold <= calm ? 0 : $urandom_range(0, 6);
        else if (out_hold > 0)
            out_hold <= out_hold - 1;
    end

    always @(negedge clk)
    begin
        out_stall <= (out_hold > 0);
    end

    // Watchdog. Leave a wide margin over a full-range query.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == 5000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One input beat. Called at a falling edge; returns at the falling edge
    // after the beat is taken.
    task automatic send_beat(input sdbl_cmd_t cmd, input logic [15:0] lon,
                             input logic [14:0] lat, input logic [12:0] mn,
                             input logic [12:0] mx, input logic [4:0] bin,
                             input logic [3:0] ln, input logic [2:0] on,
                             input logic [23:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command       <= cmd;
        lon_position  <= lon;
        lat_position  <= lat;
        min_magnitude <= mn;
        max_magnitude <= mx;
        bin_index     <= bin;
        lat_node      <= ln;
        lon_node      <= on;
        load_value    <= val;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Unused fields of each beat carry random bits.
    task automatic ask_stars(input int lon, input int lat, input int mn, input int mx);
        send_beat(CMD_QUERY, lon[15:0], lat[14:0], mn[12:0], mx[12:0], 5'($urandom()),
                  4'($urandom()), 3'($urandom()), 24'($urandom()));
    endtask

    task automatic load_break(input int bin, input int mag);
        logic [23:0] v;
        v = {8'($urandom()), mag[15:0]};
        send_beat(CMD_BREAK, 16'($urandom()), 15'($urandom()), 13'($urandom()),
                  13'($urandom()), bin[4:0], 4'($urandom()), 3'($urandom()), v);
    endtask

    task automatic load_count(input int bin, input int ln, input int on, input int val);
        send_beat(CMD_COUNT, 16'($urandom()), 15'($urandom()), 13'($urandom()),
                  13'($urandom()), bin[4:0], ln[3:0], on[2:0], val[23:0]);
    endtask

    function automatic int draw_count();
        case ($urandom_range(0, 5))
            0: return 24'hFFFFFF;
            1: return $urandom_range(0, 15);
            default: return $urandom() & 24'hFFFFFF;
        endcase
    endfunction

    // Breakpoint near the sorted ladder -1000 + 160*bin, sometimes anywhere.
    function automatic int draw_break(input int bin);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 5000) - 1000;
        return -1000 + 160 * bin + $urandom_range(0, 150);
    endfunction

    initial
    begin
        int lon;
        int lat;
        int mn;
        int mx;
        int t;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        calm          = 1'b0;
        command       = CMD_NONE;
        lon_position  = '0;
        lat_position  = '0;
        min_magnitude = '0;
        max_magnitude = '0;
        bin_index     = '0;
        lat_node      = '0;
        lon_node      = '0;
        load_value    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every entry is written before any query can read it.
        for (int b = 0; b < 32; b++) load_break(b, draw_break(b));
        calm = 1'b1;
        for (int b = 0; b < 32; b++)
            for (int ln = 0; ln < 9; ln++)
                for (int on = 0; on < 6; on++)
                    load_count(b, ln, on, draw_count());
        calm = 1'b0;

        // Directed: grid ends, top node, clamping, magnitude extremes.
        ask_stars(0, -9000, -1000, 4000);
        ask_stars(35999, 8999, -1000, 4000);
        ask_stars(36000, 9000, -4096, 4095);            // top node both axes
        ask_stars(65535, 16383, -4096, -4096);          // beyond grid, clamped
        ask_stars(0, -16384, 0, 0);
        ask_stars(1000, -1000, 500, 1500);              // exact interior nodes
        ask_stars(18000, 0, -1000, -1000);
        ask_stars(20000, 123, 4095, 4095);              // usually no minimum bin
        ask_stars(9000, 3000, 3000, -1000);             // empty range
        // breakpoint extremes, then queries on both sides of them
        load_break(31, 32767);
        ask_stars(5000, -4500, 4095, 4095);
        load_break(0, -32768);
        ask_stars(27000, 6000, -4096, -4000);
        load_break(0, -1000);
        load_break(31, 3990);
        // all-ones count at a corner that the next query reads
        load_count(3, 8, 5, 24'hFFFFFF);
        ask_stars(36000, 9000, -4096, 4095);
        // ignored beats: unused command and out-of-range load addresses
        send_beat(CMD_NONE, 16'hFFFF, 15'h7FFF, 13'h1FFF, 13'h1FFF, 5'h1F, 4'hF,
                  3'h7, 24'hFFFFFF);
        load_count(31, 15, 7, 24'h5A5A5A);
        load_count(2, 9, 2, 24'hFFFFFF);
        load_count(2, 4, 6, 24'hFFFFFF);
        ask_stars(17999, -1, -1000, 4000);

        // Random: mostly well-formed queries, some table rewrites and noise.
        for (int n = 0; n < 70; n++)
        begin
            if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            t = $urandom_range(0, 99);
            if (t < 60)
            begin
                lon = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 36000);
                lat = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) - 16384
                                                  : $urandom_range(0, 18000) - 9000;
                if ($urandom_range(0, 9) == 0)
                begin
                    mn = $urandom_range(0, 8191) - 4096;
                    mx = $urandom_range(0, 8191) - 4096;
                end
                else
                begin
                    mn = $urandom_range(0, 5000) - 1000;
                    mx = mn + $urandom_range(0, 4000 - mn);
                end
                ask_stars(lon, lat, mn, mx);
            end
            else if (t < 85)
                load_count($urandom_range(0, 31), $urandom_range(0, 8),
                           $urandom_range(0, 5), draw_count());
            else if (t < 93)
            begin
                mn = $urandom_range(0, 31);
                load_break(mn, draw_break(mn));
            end
            else if (t < 96)
                load_count($urandom_range(0, 31), $urandom_range(0, 15),
                           $urandom_range(0, 7), $urandom());
            else
                send_beat(CMD_NONE, 16'($urandom()), 15'($urandom()), 13'($urandom()),
                          13'($urandom()), 5'($urandom()), 4'($urandom()),
                          3'($urandom()), 24'($urandom()));
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
